// File: src/akps_pkg.sv
package akps_pkg;

    localparam int NumRounds = 10;
    localparam int RegIndexBits = 3;
    localparam int AddrBits = 6;
    localparam int DataBits = 64;

    typedef struct packed {
        logic [31:0] candidate;
        logic        last_candidate;
    } in_word_t;

    typedef struct packed {
        logic        match;
        logic [31:0] found_chunk;
        logic        last_result;
    } out_word_t;

    // one pipeline slot: data block, round key, echoed fields
    typedef struct packed {
        logic [127:0] data;
        logic [127:0] key;
        logic [31:0]  candidate;
        logic         last;
    } stage_t;

    typedef enum logic [RegIndexBits-1:0] {
        REG_CHUNK_POS   = 3'd0,
        REG_FIXED_HI    = 3'd1,
        REG_FIXED_LO    = 3'd2,
        REG_EXPECTED_HI = 3'd3,
        REG_EXPECTED_LO = 3'd4,
        REG_TEMPLATE_HI = 3'd5,
        REG_TEMPLATE_LO = 3'd6
    } reg_index_t;

    typedef logic [7:0] byte_table_t [256];

    localparam byte_table_t SBOX = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic byte_table_t build_inv_sbox();
        byte_table_t t;
        for (int i = 0; i < 256; i++) begin
            t[SBOX[i]] = 8'(i);
        end
        return t;
    endfunction

    localparam byte_table_t INV_SBOX = build_inv_sbox();

    typedef logic [7:0] rcon_table_t [NumRounds];

    localparam rcon_table_t RCON = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // byte i of a block, byte 0 most significant
    function automatic logic [7:0] get_byte(input logic [127:0] x, input int i);
        return x[127-8*i -: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // sub_word(rot_word(w)) with round constant on the first byte
    function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
        return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    endfunction

    function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3;
        w0 = k[127:96] ^ sub_rot(k[31:0], rc);
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3;
        w3 = k[31:0] ^ k[63:32];
        w2 = k[63:32] ^ k[95:64];
        w1 = k[95:64] ^ k[127:96];
        w0 = k[127:96] ^ sub_rot(w3, rc);
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127-8*(r+4*c) -: 8] = INV_SBOX[get_byte(s, r + 4*((c + 4 - r) & 3))];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a [4];
        logic [7:0]   m2 [4];
        logic [7:0]   m4 [4];
        logic [7:0]   m8 [4];
        logic [7:0]   m9 [4];
        logic [7:0]   mb [4];
        logic [7:0]   md [4];
        logic [7:0]   me [4];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r]  = get_byte(s, r + 4*c);
                m2[r] = xt(a[r]);
                m4[r] = xt(m2[r]);
                m8[r] = xt(m4[r]);
                m9[r] = m8[r] ^ a[r];
                mb[r] = m8[r] ^ m2[r] ^ a[r];
                md[r] = m8[r] ^ m4[r] ^ a[r];
                me[r] = m8[r] ^ m4[r] ^ m2[r];
            end
            t[127-8*(4*c) -: 8]   = me[0] ^ mb[1] ^ md[2] ^ m9[3];
            t[127-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
            t[127-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
            t[127-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
        end
        return t;
    endfunction

endpackage

// File: src/akps_key_cell.sv
// forward key schedule step, data rides along; last cell adds round key 10
module akps_key_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  akps_pkg::stage_t     in_stage,
    output logic                 in_ready,
    output logic                 out_valid,
    output akps_pkg::stage_t     out_stage,
    input  logic                 out_ready,
    input  logic [7:0]           rcon,
    input  logic                 add_key
);

    logic             valid_reg, valid_next;
    akps_pkg::stage_t stage_reg, stage_next;
    logic [127:0]     key_new;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        key_new               = akps_pkg::key_fwd(in_stage.key, rcon);
        stage_next            = in_stage;
        stage_next.key        = key_new;
        if (add_key) begin
            stage_next.data = in_stage.data ^ key_new;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// File: src/akps_dec_cell.sv
// one inverse round, round key walked backward in place
module akps_dec_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  akps_pkg::stage_t     in_stage,
    output logic                 in_ready,
    output logic                 out_valid,
    output akps_pkg::stage_t     out_stage,
    input  logic                 out_ready,
    input  logic [7:0]           rcon,
    input  logic                 mix_en
);

    logic             valid_reg, valid_next;
    akps_pkg::stage_t stage_reg, stage_next;
    logic [127:0]     key_prev;
    logic [127:0]     added;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        key_prev        = akps_pkg::key_inv(in_stage.key, rcon);
        added           = akps_pkg::inv_shift_sub(in_stage.data) ^ key_prev;
        stage_next      = in_stage;
        stage_next.key  = key_prev;
        stage_next.data = mix_en ? akps_pkg::inv_mix(added) : added;
        valid_next      = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// File: src/aes128_partial_key_search.sv
// aes-128 partial key search: one 32-bit candidate word is accepted per clock
// while s_ready is high, and one result word comes out per candidate, in order.
// the pipeline is an entry stage that builds the working block, ten key
// schedule cells that run the key forward to round key 10, ten inverse round
// cells that walk the key back while decrypting, and an output register that
// does the masked compare. each stage holds its word until the next one frees,
// so bubbles close up and input keeps flowing while a result waits.
// configuration is written over the apb port (64-bit registers at 8-byte
// steps); the user must write it only while the pipeline is empty, and the
// block itself has no check for this. chunk position 0 uses the candidate
// block as the key and compares all 16 bytes, positions 1 to 3 use the fixed
// key and compare 4k bytes.
module aes128_partial_key_search (
    input  logic                                aclk,
    input  logic                                aresetn,
    // candidate words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  akps_pkg::in_word_t                  s_data,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output akps_pkg::out_word_t                 m_data,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [akps_pkg::AddrBits-1:0]       paddr,
    input  logic [akps_pkg::DataBits-1:0]       pwdata,
    output logic [akps_pkg::DataBits-1:0]       prdata,
    output logic                                pready
);

    localparam int NumNodes = 2 * akps_pkg::NumRounds + 1;

    // configuration registers
    logic [1:0]   chunk_pos_reg;
    logic [63:0]  fixed_hi_reg, fixed_lo_reg;
    logic [63:0]  expected_hi_reg, expected_lo_reg;
    logic [63:0]  template_hi_reg, template_lo_reg;
    logic         cfg_write;
    logic [akps_pkg::RegIndexBits-1:0] reg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = paddr[akps_pkg::AddrBits-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_pos_reg   <= 2'd3;
            fixed_hi_reg    <= '0;
            fixed_lo_reg    <= '0;
            expected_hi_reg <= '0;
            expected_lo_reg <= '0;
            template_hi_reg <= '0;
            template_lo_reg <= '0;
        end else if (cfg_write) begin
            case (reg_sel)
                akps_pkg::REG_CHUNK_POS:   chunk_pos_reg   <= pwdata[1:0];
                akps_pkg::REG_FIXED_HI:    fixed_hi_reg    <= pwdata;
                akps_pkg::REG_FIXED_LO:    fixed_lo_reg    <= pwdata;
                akps_pkg::REG_EXPECTED_HI: expected_hi_reg <= pwdata;
                akps_pkg::REG_EXPECTED_LO: expected_lo_reg <= pwdata;
                akps_pkg::REG_TEMPLATE_HI: template_hi_reg <= pwdata;
                akps_pkg::REG_TEMPLATE_LO: template_lo_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            akps_pkg::REG_CHUNK_POS:   prdata = {62'd0, chunk_pos_reg};
            akps_pkg::REG_FIXED_HI:    prdata = fixed_hi_reg;
            akps_pkg::REG_FIXED_LO:    prdata = fixed_lo_reg;
            akps_pkg::REG_EXPECTED_HI: prdata = expected_hi_reg;
            akps_pkg::REG_EXPECTED_LO: prdata = expected_lo_reg;
            akps_pkg::REG_TEMPLATE_HI: prdata = template_hi_reg;
            akps_pkg::REG_TEMPLATE_LO: prdata = template_lo_reg;
            default:                   prdata = '0;
        endcase
    end

    // pipeline nodes: node 0 is the entry register, node n the output of cell n-1
    logic             node_valid [NumNodes];
    akps_pkg::stage_t node_stage [NumNodes];
    logic             node_ready [NumNodes];

    // entry stage: drop the candidate into the template at chunk k
    logic             entry_valid_reg, entry_valid_next;
    akps_pkg::stage_t entry_stage_reg, entry_stage_next;
    logic [127:0]     block;
    logic [127:0]     fixed_blk;

    assign s_ready = !entry_valid_reg || node_ready[0];

    always_comb begin
        block     = {template_hi_reg, template_lo_reg};
        fixed_blk = {fixed_hi_reg, fixed_lo_reg};
        case (chunk_pos_reg)
            2'd0:    block[127:96] = s_data.candidate;
            2'd1:    block[95:64]  = s_data.candidate;
            2'd2:    block[63:32]  = s_data.candidate;
            default: block[31:0]   = s_data.candidate;
        endcase
        entry_stage_next.candidate = s_data.candidate;
        entry_stage_next.last      = s_data.last_candidate;
        // position 0: candidate block is the key, fixed block is the ciphertext
        if (chunk_pos_reg == 2'd0) begin
            entry_stage_next.key  = block;
            entry_stage_next.data = fixed_blk;
        end else begin
            entry_stage_next.key  = fixed_blk;
            entry_stage_next.data = block;
        end
        entry_valid_next = s_ready ? s_valid : entry_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= 1'b0;
        end else begin
            entry_valid_reg <= entry_valid_next;
        end
        if (s_ready && s_valid) begin
            entry_stage_reg <= entry_stage_next;
        end
    end

    assign node_valid[0] = entry_valid_reg;
    assign node_stage[0] = entry_stage_reg;

    // key schedule cells, round keys 1..10; the last one adds round key 10
    for (genvar j = 0; j < akps_pkg::NumRounds; j++) begin : g_key
        akps_key_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (node_valid[j]),
            .in_stage  (node_stage[j]),
            .in_ready  (node_ready[j]),
            .out_valid (node_valid[j+1]),
            .out_stage (node_stage[j+1]),
            .out_ready (node_ready[j+1]),
            .rcon      (akps_pkg::RCON[j]),
            .add_key   (j == akps_pkg::NumRounds - 1)
        );
    end

    // inverse rounds 9 down to 0; round 0 skips the inverse mix
    for (genvar d = 0; d < akps_pkg::NumRounds; d++) begin : g_dec
        akps_dec_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (node_valid[akps_pkg::NumRounds+d]),
            .in_stage  (node_stage[akps_pkg::NumRounds+d]),
            .in_ready  (node_ready[akps_pkg::NumRounds+d]),
            .out_valid (node_valid[akps_pkg::NumRounds+d+1]),
            .out_stage (node_stage[akps_pkg::NumRounds+d+1]),
            .out_ready (node_ready[akps_pkg::NumRounds+d+1]),
            .rcon      (akps_pkg::RCON[akps_pkg::NumRounds-1-d]),
            .mix_en    (d != akps_pkg::NumRounds - 1)
        );
    end

    // output register with masked compare
    logic                m_valid_reg, m_valid_next;
    akps_pkg::out_word_t m_data_reg, m_data_next;
    logic [127:0]        cmp_mask;
    akps_pkg::stage_t    last_stage;

    assign last_stage             = node_stage[NumNodes-1];
    assign node_ready[NumNodes-1] = !m_valid_reg || m_ready;

    always_comb begin
        case (chunk_pos_reg)
            2'd0:    cmp_mask = '1;
            2'd1:    cmp_mask = {32'hffff_ffff, 96'd0};
            2'd2:    cmp_mask = {64'hffff_ffff_ffff_ffff, 64'd0};
            default: cmp_mask = {96'hffff_ffff_ffff_ffff_ffff_ffff, 32'd0};
        endcase
        m_data_next.match = ((last_stage.data ^ {expected_hi_reg, expected_lo_reg})
                             & cmp_mask) == '0;
        m_data_next.found_chunk = last_stage.candidate;
        m_data_next.last_result = last_stage.last;
        m_valid_next = node_ready[NumNodes-1] ? node_valid[NumNodes-1] : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (node_ready[NumNodes-1] && node_valid[NumNodes-1]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: tb/tb_aes128_partial_key_search.sv
module tb_aes128_partial_key_search;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int WatchdogLimit = 20000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    akps_pkg::in_word_t s_data;
    logic m_valid;
    logic m_ready;
    akps_pkg::out_word_t m_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [akps_pkg::AddrBits-1:0] paddr;
    logic [akps_pkg::DataBits-1:0] pwdata;
    logic [akps_pkg::DataBits-1:0] prdata;
    logic pready;

    aes128_partial_key_search u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // shadow of the configuration
    logic [1:0]   chunk_pos;
    logic [127:0] fixed_blk;
    logic [127:0] expected_blk;
    logic [127:0] template_blk;

    logic [7:0] sub_tab [256];
    logic [7:0] inv_sub_tab [256];

    akps_pkg::in_word_t  cand_q [$];
    akps_pkg::out_word_t result_q [$];
    int errors;
    int quiet_cycles;
    logic apb_busy;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = xtime(a);
        end
        return r;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] v, input int s);
        return (v << s) | (v >> (8 - s));
    endfunction

    // s-box from the field inverse and affine map
    task automatic build_sub_tables();
        logic [7:0] inv;
        logic [7:0] s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            if (x != 0) begin
                for (int y = 1; y < 256; y++) begin
                    if (gf_mul(8'(x), 8'(y)) == 8'h01) begin
                        inv = 8'(y);
                        break;
                    end
                end
            end
            s = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
            sub_tab[x] = s;
            inv_sub_tab[s] = 8'(x);
        end
    endtask

    function automatic logic [7:0] byte_at(input logic [127:0] x, input int i);
        return x[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t = {sub_tab[k[23:16]] ^ rc, sub_tab[k[15:8]], sub_tab[k[7:0]], sub_tab[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[127-8*(r+4*c) -: 8] = inv_sub_tab[byte_at(s, r + 4*((c + 4 - r) & 3))];
        return t;
    endfunction

    function automatic logic [127:0] unmix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = byte_at(s, 4*c);
            a1 = byte_at(s, 4*c+1);
            a2 = byte_at(s, 4*c+2);
            a3 = byte_at(s, 4*c+3);
            t[127-32*c -: 8] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11)
                             ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9);
            t[119-32*c -: 8] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14)
                             ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13);
            t[111-32*c -: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)
                             ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11);
            t[103-32*c -: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13)
                             ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14);
        end
        return t;
    endfunction

    function automatic logic [127:0] aes_decrypt(input logic [127:0] ct, input logic [127:0] key);
        logic [127:0] rk [11];
        logic [127:0] s;
        logic [7:0] rc;
        rk[0] = key;
        rc = 8'h01;
        for (int r = 1; r <= 10; r++) begin
            rk[r] = next_round_key(rk[r-1], rc);
            rc = xtime(rc);
        end
        s = ct ^ rk[10];
        for (int r = 9; r >= 1; r--) begin
            s = unshift_unsub(s) ^ rk[r];
            s = unmix_columns(s);
        end
        return unshift_unsub(s) ^ rk[0];
    endfunction

    function automatic logic [127:0] working_block(input logic [127:0] tmpl, input logic [1:0] k,
                                                   input logic [31:0] cand);
        logic [127:0] b;
        b = tmpl;
        b[127-32*k -: 32] = cand;
        return b;
    endfunction

    // decrypted block for a candidate under the current settings
    function automatic logic [127:0] candidate_plain(input logic [1:0] k, input logic [31:0] cand);
        logic [127:0] blk;
        blk = working_block(template_blk, k, cand);
        if (k == 2'd0) return aes_decrypt(fixed_blk, blk);
        return aes_decrypt(blk, fixed_blk);
    endfunction

    function automatic akps_pkg::out_word_t search_predict(input akps_pkg::in_word_t w);
        akps_pkg::out_word_t r;
        logic [127:0] dec;
        logic hit;
        dec = candidate_plain(chunk_pos, w.candidate);
        hit = 1'b1;
        for (int j = 0; j < 16; j++)
            if ((chunk_pos == 2'd0 || j < 4*chunk_pos)
                && byte_at(dec, j) != byte_at(expected_blk, j))
                hit = 1'b0;
        r.match = hit;
        r.found_chunk = w.candidate;
        r.last_result = w.last_candidate;
        return r;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // candidate driver with random gaps, bursts when gap_max is zero
    int gap_left;
    int gap_max;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) result_q = {result_q, search_predict(s_data)};
            if (s_valid && !s_ready) begin
                // hold the word
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (cand_q.size() > 0) begin
                s_valid <= 1'b1;
                s_data <= cand_q.pop_front();
                gap_left <= $urandom_range(gap_max, 0);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor with random stalls, no gap when the draw is zero
    int stall_left;
    int stall_max;
    int stall_draw;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $display("%0t unexpected word: expected none, actual %h", $time, m_data);
                    errors++;
                end else begin
                    if (m_data !== result_q[0]) begin
                        $display("%0t mismatch: expected m=%b c=%h l=%b, actual m=%b c=%h l=%b",
                                 $time, result_q[0].match, result_q[0].found_chunk,
                                 result_q[0].last_result, m_data.match, m_data.found_chunk,
                                 m_data.last_result);
                        errors++;
                    end
                    void'(result_q.pop_front());
                end
                stall_draw = $urandom_range(stall_max, 0);
                if (stall_draw == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    stall_left <= stall_draw - 1;
                    m_ready <= 1'b0;
                end
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || apb_busy || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("[aes128_partial_key_search] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            akps_pkg::REG_CHUNK_POS:   chunk_pos = val[1:0];
            akps_pkg::REG_FIXED_HI:    fixed_blk[127:64] = val;
            akps_pkg::REG_FIXED_LO:    fixed_blk[63:0] = val;
            akps_pkg::REG_EXPECTED_HI: expected_blk[127:64] = val;
            akps_pkg::REG_EXPECTED_LO: expected_blk[63:0] = val;
            akps_pkg::REG_TEMPLATE_HI: template_blk[127:64] = val;
            akps_pkg::REG_TEMPLATE_LO: template_blk[63:0] = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (cand_q.size() > 0 || s_valid || result_q.size() > 0) @(posedge aclk);
        // pipeline is 22 deep, let it settle
        repeat (30) @(posedge aclk);
    endtask

    function automatic logic [127:0] pick_block(input int mode);
        case (mode)
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    task automatic run_sweep(input logic [1:0] k, input int mode, input int n);
        logic [31:0] hit_cand;
        logic [127:0] plain;
        logic [127:0] fix;
        logic [127:0] tmpl;
        akps_pkg::in_word_t w;
        int pick;
        apb_busy = 1'b1;
        fix = pick_block(mode);
        tmpl = pick_block((mode + 1) % 3);
        apb_write(akps_pkg::REG_CHUNK_POS, {$urandom, 24'($urandom), 6'(0), k});
        apb_write(akps_pkg::REG_FIXED_HI, fix[127:64]);
        apb_write(akps_pkg::REG_FIXED_LO, fix[63:0]);
        apb_write(akps_pkg::REG_TEMPLATE_HI, tmpl[127:64]);
        apb_write(akps_pkg::REG_TEMPLATE_LO, tmpl[63:0]);
        // plant a matching candidate, junk in bytes that are not compared
        hit_cand = (mode == 0) ? 32'h0000_0000 : (mode == 1) ? 32'hffff_ffff : $urandom;
        plain = candidate_plain(k, hit_cand);
        if (k != 2'd0)
            for (int j = 4*k; j < 16; j++) plain[127-8*j -: 8] = 8'($urandom);
        apb_write(akps_pkg::REG_EXPECTED_HI, plain[127:64]);
        apb_write(akps_pkg::REG_EXPECTED_LO, plain[63:0]);
        // out of range index must be ignored
        apb_write(REG_UNUSED, {$urandom, $urandom});
        apb_busy = 1'b0;
        gap_max = ($urandom_range(3, 0) == 0) ? 0 : 13;
        stall_max = ($urandom_range(3, 0) == 0) ? 0 : 13;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(7, 0);
            if (pick == 0) w.candidate = hit_cand;
            else if (pick == 1) w.candidate = hit_cand ^ (32'h1 << $urandom_range(31, 0));
            else w.candidate = $urandom;
            w.last_candidate = (i == n - 1) ? 1'b1 : 1'($urandom);
            cand_q = {cand_q, w};
        end
        wait_drained();
    endtask

    initial begin
        akps_pkg::in_word_t w;
        logic [31:0] edge_vals [6];
        errors = 0;
        quiet_cycles = 0;
        apb_busy = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        chunk_pos = 2'd3;
        fixed_blk = '0;
        expected_blk = '0;
        template_blk = '0;
        gap_max = 0;
        stall_max = 0;
        build_sub_tables();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, edge candidates, back to back
        edge_vals = '{32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h1, 32'h7fff_ffff, 32'ha5a5_5a5a};
        for (int i = 0; i < 12; i++) begin
            w.candidate = edge_vals[i % 6];
            w.last_candidate = 1'(i);
            cand_q = {cand_q, w};
        end
        wait_drained();

        // short directed sweeps at every position, then the random part
        for (int k = 0; k < 4; k++) run_sweep(2'(k), k % 3, 4);
        for (int p = 0; p < 16; p++) run_sweep(2'($urandom_range(3, 0)), p % 3, 38);

        while (result_q.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0) begin
            $display("[aes128_partial_key_search] OK");
        end else begin
            $display("[aes128_partial_key_search] ERROR");
        end
        $finish;
    end

endmodule
